// ===== rtl/core/name_table_insert_delete_search_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Name table assertion macros
// Shared assertion forms for the name table checker.
// ----------------------------------------------------------------------------
`ifndef NAME_TABLE_INSERT_DELETE_SEARCH_UNIT_MACROS_SVH
`define NAME_TABLE_INSERT_DELETE_SEARCH_UNIT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define NTIS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define NTIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ntis_pkg.sv =====
// ----------------------------------------------------------------------------
// Name table package
// Command and status codes, the stored entry type and the cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package ntis_pkg;

  // Command carried by one input transaction.
  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  // Status carried by one result transaction.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned SLOT_W = 5;

  // One stored name, three words of eight bytes each.
  typedef struct packed {
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w0;
  } entry_t;

  // Broadcast control for every cell of the chain.
  typedef struct packed {
    logic shift;   // cells below the position take their upper neighbor
    logic ins_en;  // the cell at the position takes the insert data
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ntis_cell.sv =====
// ----------------------------------------------------------------------------
// Name table cell
// Holds one entry; shifts from its upper neighbor or loads insert data.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_cell #(
  parameter int unsigned POS_W = 6,
  parameter int unsigned INDEX = 0
) (
  input  wire logic                clk_i,
  input  wire ntis_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [POS_W-1:0]    pos_i,
  input  wire ntis_pkg::entry_t    next_i,
  input  wire ntis_pkg::entry_t    ins_i,
  output ntis_pkg::entry_t         ent_o
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  ntis_pkg::entry_t ent_d, ent_q;
  logic             below, at_pos;

  // Position decode against the broadcast position.
  assign below  = (MY_IDX < pos_i);
  assign at_pos = (MY_IDX == pos_i);

  // Next entry: shift down, insert, or hold.
  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.shift && below) begin
      ent_d = next_i;
    end else if (ctrl_i.ins_en && at_pos) begin
      ent_d = ins_i;
    end
  end

  // Entry storage holds payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

// ===== rtl/core/name_table_insert_delete_search_unit.sv =====
// ----------------------------------------------------------------------------
// Name table insert, delete and search unit
// Single-level directory of names kept in a chain of entry cells.
// ----------------------------------------------------------------------------
// The table is a chain of MAX_FILES cells, and entry 0 always sits in the
// bottom cell. One command is handled at a time: a transaction is taken
// while the block is idle, and its work starts once the output register can
// take a result. Create writes the cell at the current count and registers
// its result. Delete, search and list rotate the chain once, one entry per
// cycle through the bottom cell; list gives one result per cycle of the
// rotation, and delete drops the first matching entry as it passes. The
// rotation advances only while the output register is free or being taken,
// so a stalled output holds it. Stored names have no reset value; the entry
// count resets to zero and no clearing pass is needed.
`default_nettype none

module name_table_insert_delete_search_unit #(
  parameter int unsigned MAX_FILES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [63:0] name_w0_i,
  input  wire logic [63:0] name_w1_i,
  input  wire logic [63:0] name_w2_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [4:0]       slot_o,
  output logic [63:0]      out_w0_o,
  output logic [63:0]      out_w1_o,
  output logic [63:0]      out_w2_o,
  output logic             last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FILES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FILES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam int unsigned SLOT_W = ntis_pkg::SLOT_W;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e                state_d, state_q;
  ntis_pkg::cmd_e        cmd_d, cmd_q;
  ntis_pkg::entry_t      key_d, key_q;
  logic [CNT_W-1:0]      cnt_d, cnt_q;
  logic [CNT_W-1:0]      total_d, total_q;
  logic [CNT_W-1:0]      step_d, step_q;
  logic [CNT_W-1:0]      fpos_d, fpos_q;
  logic                  found_d, found_q;

  logic                  ovalid_d, ovalid_q;
  ntis_pkg::status_e     status_d, status_q;
  logic [SLOT_W-1:0]     slot_d, slot_q;
  ntis_pkg::entry_t      odata_d, odata_q;
  logic                  last_d, last_q;

  ntis_pkg::cell_ctrl_t  ctrl;
  logic [CNT_W-1:0]      pos;
  ntis_pkg::entry_t      ins;
  ntis_pkg::entry_t      ent [MAX_FILES];

  logic                  step_en, hit, final_step;
  logic [CNT_W-1:0]      slot_src;

  // Chain of entry cells; the top cell shifts in zeros.
  for (genvar gi = 0; gi < MAX_FILES; gi++) begin : g_cell
    ntis_pkg::entry_t nxt;
    if (gi == MAX_FILES - 1) begin : g_top
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = ent[gi+1];
    end
    ntis_cell #(
      .POS_W (CNT_W),
      .INDEX (gi)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .pos_i  (pos),
      .next_i (nxt),
      .ins_i  (ins),
      .ent_o  (ent[gi])
    );
  end

  // Work advances only when the output register can take a result.
  assign step_en    = (state_q == S_RUN) && (!ovalid_q || out_ready_i);
  assign hit        = (ent[0] == key_q) && !found_q;
  assign final_step = (step_q == total_q - CNT_ONE);
  assign in_ready_o = (state_q == S_IDLE);

  // Command sequencer and cell control.
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    cnt_d    = cnt_q;
    total_d  = total_q;
    step_d   = step_q;
    fpos_d   = fpos_q;
    found_d  = found_q;
    ovalid_d = ovalid_q;
    status_d = status_q;
    slot_d   = slot_q;
    odata_d  = odata_q;
    last_d   = last_q;
    ctrl     = '0;
    pos      = cnt_q - CNT_ONE;
    ins      = ent[0];
    slot_src = '0;

    // A result that is taken leaves the output register.
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = ntis_pkg::cmd_e'(cmd_i);
          key_d   = '{w2: name_w2_i, w1: name_w1_i, w0: name_w0_i};
          total_d = cnt_q;
          step_d  = '0;
          fpos_d  = '0;
          found_d = 1'b0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (step_en) begin
          ovalid_d = 1'b0;
          odata_d  = '0;
          last_d   = 1'b1;
          unique case (cmd_q)
            ntis_pkg::CMD_CREATE: begin
              ovalid_d = 1'b1;
              state_d  = S_IDLE;
              if (cnt_q == CNT_MAX) begin
                status_d = ntis_pkg::ST_FULL;
              end else begin
                ctrl.ins_en = 1'b1;
                pos         = cnt_q;
                ins         = key_q;
                status_d    = ntis_pkg::ST_OK;
                slot_src    = cnt_q;
                cnt_d       = cnt_q + CNT_ONE;
              end
            end
            ntis_pkg::CMD_LIST: begin
              ovalid_d = 1'b1;
              if (total_q == '0) begin
                status_d = ntis_pkg::ST_EMPTY;
                state_d  = S_IDLE;
              end else begin
                // Emit the bottom entry and rotate it to the highest occupied cell.
                ctrl.shift  = 1'b1;
                ctrl.ins_en = 1'b1;
                status_d    = ntis_pkg::ST_OK;
                slot_src    = step_q;
                odata_d     = ent[0];
                last_d      = final_step;
                step_d      = step_q + CNT_ONE;
                if (final_step) begin
                  state_d = S_IDLE;
                end
              end
            end
            default: begin
              // Delete and search rotate the whole table once.
              if (total_q == '0) begin
                ovalid_d = 1'b1;
                status_d = ntis_pkg::ST_NOTFOUND;
                state_d  = S_IDLE;
              end else begin
                ctrl.shift = 1'b1;
                if (hit) begin
                  found_d = 1'b1;
                  fpos_d  = step_q;
                end
                if ((cmd_q == ntis_pkg::CMD_DELETE) && hit) begin
                  // Drop the matching entry instead of rotating it.
                  ctrl.ins_en = 1'b0;
                  cnt_d       = cnt_q - CNT_ONE;
                end else begin
                  ctrl.ins_en = 1'b1;
                end
                step_d = step_q + CNT_ONE;
                if (final_step) begin
                  ovalid_d = 1'b1;
                  state_d  = S_IDLE;
                  if (found_q || hit) begin
                    status_d = ntis_pkg::ST_OK;
                    slot_src = hit ? step_q : fpos_q;
                  end else begin
                    status_d = ntis_pkg::ST_NOTFOUND;
                  end
                end
              end
            end
          endcase
          slot_d = SLOT_W'(slot_src);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, counters and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= ntis_pkg::CMD_CREATE;
      key_q    <= '0;
      cnt_q    <= '0;
      total_q  <= '0;
      step_q   <= '0;
      fpos_q   <= '0;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
      status_q <= ntis_pkg::ST_OK;
      slot_q   <= '0;
      odata_q  <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      key_q    <= key_d;
      cnt_q    <= cnt_d;
      total_q  <= total_d;
      step_q   <= step_d;
      fpos_q   <= fpos_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
      status_q <= status_d;
      slot_q   <= slot_d;
      odata_q  <= odata_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign out_w0_o    = odata_q.w0;
  assign out_w1_o    = odata_q.w1;
  assign out_w2_o    = odata_q.w2;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/ntis_checker.sv =====
// ----------------------------------------------------------------------------
// Name table port checker
// Watches the top-level ports of the name table over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "name_table_insert_delete_search_unit_macros.svh"

module ntis_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [4:0]  slot_o,
  input wire logic [63:0] out_w0_o,
  input wire logic [63:0] out_w1_o,
  input wire logic [63:0] out_w2_o,
  input wire logic        last_o
);

  logic in_xact, stall, err_status;

  assign in_xact    = in_valid_i && in_ready_o;
  assign stall      = out_valid_o && !out_ready_i;
  assign err_status = (status_o != ntis_pkg::ST_OK);

  // A stalled result transaction holds its status, slot, first name word and last flag.
  `NTIS_ASSERT(a_out_hold, clk_i, rst_ni, stall |=> out_valid_o && $stable(status_o) && $stable(slot_o) && $stable(out_w0_o) && $stable(last_o), "result changed while stalled")

  // Only one command is in work at a time.
  `NTIS_ASSERT(a_one_cmd, clk_i, rst_ni, in_xact |=> !in_ready_o, "input taken while busy")

  // Error and empty results carry no position and no name and close the command.
  `NTIS_ASSERT(a_err_result, clk_i, rst_ni, (out_valid_o && err_status) |-> (slot_o == 5'd0) && last_o && (out_w0_o == 64'd0) && (out_w1_o == 64'd0) && (out_w2_o == 64'd0), "malformed error result")

  // Reset leaves the block idle with no result pending.
  `NTIS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> in_ready_o && !out_valid_o, "not idle in reset")

endmodule

bind name_table_insert_delete_search_unit ntis_checker u_ntis_checker (.*);

`default_nettype wire
